[design/bet_pkg.sv]
// ----------------------------------------------------------------------------
// bet_pkg
// Shared types and constants for the breakpoint envelope table.
// ----------------------------------------------------------------------------
package bet_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int TIME_BITS_DEF = 24;
  localparam int TIME_FIELD_W  = 24;
  localparam int LEVEL_W       = 10;
  localparam int OUT_W         = 36;
  localparam int TOTAL_W       = 7;
  localparam int LEVEL_MAX     = 1000;
  localparam int RESET_END_MS  = 60000;

  typedef enum logic [1:0] {
    ACT_CLEAR         = 2'd0,
    ACT_INSERT        = 2'd1,
    ACT_INSERT_INTERP = 2'd2,
    ACT_EVAL          = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2
  } status_e;

  typedef struct packed {
    action_e                   action;
    logic [TIME_FIELD_W-1:0]   time_ms;
    logic [LEVEL_W-1:0]        level_in;
  } cmd_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]   level_out;
    status_e                   status;
    logic [TOTAL_W-1:0]        node_total;
  } result_t;

  typedef struct packed {
    logic rot;
    logic ins;
  } cell_ctl_t;

endpackage

[design/breakpoint_envelope_table.sv]
// ----------------------------------------------------------------------------
// breakpoint_envelope_table
// Time-sorted envelope breakpoint table with linear interpolation.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on result_o for one cycle with valid_o and cannot be held off.
// Clear, insert with a given level, a refused insert and any command on a
// table with fewer than two nodes answer in the cycle after acceptance.
// For evaluate and interpolated insert the node ring rotates once past its
// head cell to locate the segment, then a multiply and a one-bit-per-cycle
// divider produce the level; a zero-length segment skips the divider.
module breakpoint_envelope_table #(
  parameter int MAX_NODES = bet_pkg::MAX_NODES_DEF,
  parameter int TIME_BITS = bet_pkg::TIME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  bet_pkg::cmd_t    cmd_i,
  output logic             valid_o,
  output bet_pkg::result_t result_o
);

  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int IW = $clog2(MAX_NODES);
  localparam int LW = bet_pkg::LEVEL_W;
  localparam int PW = TIME_BITS + 12;
  localparam int SW = (PW + 2 > 37) ? PW + 2 : 37;
  localparam int FW = bet_pkg::TIME_FIELD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MUL, S_ABS, S_DIV, S_FIN
  } state_e;

  state_e                   state_q;
  bet_pkg::action_e         act_q;
  logic [TIME_BITS-1:0]     t_q;
  logic [CW-1:0]            cnt_q;
  logic [IW-1:0]            scan_q;
  logic [TIME_BITS-1:0]     x1_q, x2_q;
  logic [LW-1:0]            y1_q, y2_q;
  logic                     adv_q;
  logic signed [PW-1:0]     prod_q;
  logic                     neg_q;
  logic                     zero_q;
  logic                     valid_q;
  bet_pkg::result_t         res_q;

  logic [FW+TIME_BITS-1:0]  t_ext;
  logic [TIME_BITS-1:0]     t_in;
  logic [LW-1:0]            lvl_in;
  logic                     accept, full, few;
  logic                     ins_now, ins_fin;
  bet_pkg::cell_ctl_t       ctl;
  logic [TIME_BITS-1:0]     new_time, t_cmp;
  logic [LW-1:0]            new_level;
  logic [TIME_BITS-1:0]     cell_time  [MAX_NODES];
  logic [LW-1:0]            cell_level [MAX_NODES];
  logic                     cell_ge    [MAX_NODES];
  logic                     adv;
  logic signed [TIME_BITS:0] diff;
  logic signed [LW:0]       dy;
  logic signed [PW-1:0]     prod_d;
  logic [PW-1:0]            mag;
  logic                     div_start, div_done;
  logic [PW-1:0]            quo;
  logic signed [SW-1:0]     qs, sum, sat;
  logic [LW-1:0]            lvl_clamp;
  logic [CW+bet_pkg::TOTAL_W-1:0] cnt_ext, cnt_inc_ext;

  assign t_ext  = {{TIME_BITS{1'b0}}, cmd_i.time_ms};
  assign t_in   = t_ext[TIME_BITS-1:0];
  assign lvl_in = (cmd_i.level_in > LW'(bet_pkg::LEVEL_MAX))
                  ? LW'(bet_pkg::LEVEL_MAX) : cmd_i.level_in;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && (state_q == S_IDLE);
  assign full   = (cnt_q >= CW'(MAX_NODES));
  assign few    = (cnt_q < CW'(2));

  assign ins_now = accept && !full &&
                   ((cmd_i.action == bet_pkg::ACT_INSERT) ||
                    (cmd_i.action == bet_pkg::ACT_INSERT_INTERP && few));
  assign ins_fin = (state_q == S_FIN) && (act_q == bet_pkg::ACT_INSERT_INTERP);

  assign ctl.ins   = ins_now || ins_fin;
  assign ctl.rot   = (state_q == S_SCAN);
  assign t_cmp     = (state_q == S_IDLE) ? t_in : t_q;
  assign new_time  = ins_fin ? t_q : t_in;
  assign new_level = ins_fin ? lvl_clamp :
                     ((cmd_i.action == bet_pkg::ACT_INSERT) ? lvl_in : '0);

  for (genvar j = 0; j < MAX_NODES; j++) begin : g_cell
    localparam int NXT = (j + 1) % MAX_NODES;
    localparam logic [TIME_BITS-1:0] RT =
      (j == 1) ? TIME_BITS'(bet_pkg::RESET_END_MS) : '0;
    localparam logic [LW-1:0] RL = (j < 2) ? LW'(bet_pkg::LEVEL_MAX) : '0;
    logic [TIME_BITS-1:0] p_time;
    logic [LW-1:0]        p_level;
    logic                 p_ge;
    if (j == 0) begin : g_head
      assign p_time  = new_time;
      assign p_level = new_level;
      assign p_ge    = 1'b0;
    end else begin : g_body
      assign p_time  = cell_time[j-1];
      assign p_level = cell_level[j-1];
      assign p_ge    = cell_ge[j-1];
    end
    bet_cell #(
      .TIME_BITS (TIME_BITS),
      .CW        (CW),
      .IDX       (j),
      .RST_TIME  (RT),
      .RST_LEVEL (RL)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .count_i      (cnt_q),
      .t_cmp_i      (t_cmp),
      .new_time_i   (new_time),
      .new_level_i  (new_level),
      .prev_time_i  (p_time),
      .prev_level_i (p_level),
      .prev_ge_i    (p_ge),
      .next_time_i  (cell_time[NXT]),
      .next_level_i (cell_level[NXT]),
      .time_o       (cell_time[j]),
      .level_o      (cell_level[j]),
      .ge_o         (cell_ge[j])
    );
  end

  assign adv = ((scan_q == '0) || adv_q) &&
               (CW'(scan_q) < cnt_q - CW'(1)) && (t_q >= cell_time[0]);

  assign diff   = $signed({1'b0, t_q}) - $signed({1'b0, x1_q});
  assign dy     = $signed({1'b0, y2_q}) - $signed({1'b0, y1_q});
  assign prod_d = diff * dy;
  assign mag    = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
  assign div_start = (state_q == S_ABS) && !zero_q;

  bet_div #(
    .NW (PW),
    .DW (TIME_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (x2_q - x1_q),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  assign qs  = neg_q ? -$signed(SW'(quo)) : $signed(SW'(quo));
  assign sum = zero_q ? $signed(SW'(y1_q)) : qs + $signed(SW'(y1_q));
  always_comb begin
    if (sum > $signed(SW'(36'h7FFFFFFFF))) begin
      sat = $signed(SW'(36'h7FFFFFFFF));
    end else if (sum < $signed({{(SW-35){1'b1}}, 35'b0})) begin
      sat = $signed({{(SW-35){1'b1}}, 35'b0});
    end else begin
      sat = sum;
    end
    if (sum < 0) begin
      lvl_clamp = '0;
    end else if (sum > $signed(SW'(bet_pkg::LEVEL_MAX))) begin
      lvl_clamp = LW'(bet_pkg::LEVEL_MAX);
    end else begin
      lvl_clamp = sum[LW-1:0];
    end
  end

  assign cnt_ext     = {{bet_pkg::TOTAL_W{1'b0}}, cnt_q};
  assign cnt_inc_ext = {{bet_pkg::TOTAL_W{1'b0}}, cnt_q + CW'(1)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CW'(2);
      valid_q <= 1'b0;
      scan_q  <= '0;
      adv_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            act_q           <= cmd_i.action;
            t_q             <= t_in;
            scan_q          <= '0;
            adv_q           <= 1'b0;
            res_q.level_out <= '0;
            res_q.status    <= bet_pkg::ST_OK;
            res_q.node_total <= cnt_ext[bet_pkg::TOTAL_W-1:0];
            unique case (cmd_i.action)
              bet_pkg::ACT_CLEAR: begin
                cnt_q            <= '0;
                res_q.node_total <= '0;
                valid_q          <= 1'b1;
              end
              bet_pkg::ACT_INSERT: begin
                valid_q <= 1'b1;
                if (full) begin
                  res_q.status <= bet_pkg::ST_FULL;
                end else begin
                  cnt_q            <= cnt_q + CW'(1);
                  res_q.level_out  <= {{(bet_pkg::OUT_W-LW){1'b0}}, lvl_in};
                  res_q.node_total <= cnt_inc_ext[bet_pkg::TOTAL_W-1:0];
                end
              end
              bet_pkg::ACT_INSERT_INTERP: begin
                if (full) begin
                  res_q.status <= bet_pkg::ST_FULL;
                  valid_q      <= 1'b1;
                end else if (few) begin
                  res_q.status     <= bet_pkg::ST_FEW;
                  cnt_q            <= cnt_q + CW'(1);
                  res_q.node_total <= cnt_inc_ext[bet_pkg::TOTAL_W-1:0];
                  valid_q          <= 1'b1;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              bet_pkg::ACT_EVAL: begin
                if (few) begin
                  res_q.status <= bet_pkg::ST_FEW;
                  valid_q      <= 1'b1;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          adv_q  <= adv;
          scan_q <= scan_q + IW'(1);
          if (scan_q == '0) begin
            x1_q <= cell_time[0];
            y1_q <= cell_level[0];
          end else if (scan_q == IW'(1)) begin
            x2_q <= cell_time[0];
            y2_q <= cell_level[0];
          end else if (adv_q) begin
            x1_q <= x2_q;
            y1_q <= y2_q;
            x2_q <= cell_time[0];
            y2_q <= cell_level[0];
          end
          if (scan_q == IW'(MAX_NODES - 1)) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= prod_d;
          zero_q  <= (x2_q == x1_q);
          state_q <= S_ABS;
        end
        S_ABS: begin
          neg_q   <= prod_q[PW-1];
          state_q <= zero_q ? S_FIN : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          valid_q <= 1'b1;
          state_q <= S_IDLE;
          if (act_q == bet_pkg::ACT_INSERT_INTERP) begin
            cnt_q            <= cnt_q + CW'(1);
            res_q.level_out  <= {{(bet_pkg::OUT_W-LW){1'b0}}, lvl_clamp};
            res_q.node_total <= cnt_inc_ext[bet_pkg::TOTAL_W-1:0];
          end else begin
            res_q.level_out <= sat[bet_pkg::OUT_W-1:0];
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

[design/bet_cell.sv]
// ----------------------------------------------------------------------------
// bet_cell
// One breakpoint slot of the ring: shifts right on insert, rotates on scan.
// ----------------------------------------------------------------------------
module bet_cell #(
  parameter int TIME_BITS = bet_pkg::TIME_BITS_DEF,
  parameter int CW        = 7,
  parameter int IDX       = 0,
  parameter logic [TIME_BITS-1:0]        RST_TIME  = '0,
  parameter logic [bet_pkg::LEVEL_W-1:0] RST_LEVEL = '0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bet_pkg::cell_ctl_t            ctl_i,
  input  logic [CW-1:0]                 count_i,
  input  logic [TIME_BITS-1:0]          t_cmp_i,
  input  logic [TIME_BITS-1:0]          new_time_i,
  input  logic [bet_pkg::LEVEL_W-1:0]   new_level_i,
  input  logic [TIME_BITS-1:0]          prev_time_i,
  input  logic [bet_pkg::LEVEL_W-1:0]   prev_level_i,
  input  logic                          prev_ge_i,
  input  logic [TIME_BITS-1:0]          next_time_i,
  input  logic [bet_pkg::LEVEL_W-1:0]   next_level_i,
  output logic [TIME_BITS-1:0]          time_o,
  output logic [bet_pkg::LEVEL_W-1:0]   level_o,
  output logic                          ge_o
);

  logic [TIME_BITS-1:0]        time_q;
  logic [bet_pkg::LEVEL_W-1:0] level_q;

  assign ge_o    = (CW'(IDX) >= count_i) || (time_q >= t_cmp_i);
  assign time_o  = time_q;
  assign level_o = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= RST_TIME;
      level_q <= RST_LEVEL;
    end else if (ctl_i.ins && ge_o) begin
      if (prev_ge_i) begin
        time_q  <= prev_time_i;
        level_q <= prev_level_i;
      end else begin
        time_q  <= new_time_i;
        level_q <= new_level_i;
      end
    end else if (ctl_i.rot) begin
      time_q  <= next_time_i;
      level_q <= next_level_i;
    end
  end

endmodule

[design/bet_div.sv]
// ----------------------------------------------------------------------------
// bet_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bet_div #(
  parameter int NW = 36,
  parameter int DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [NW-1:0] quotient_o,
  output logic          done_o
);

  localparam int CNW = $clog2(NW + 1);

  logic [DW:0]     rem_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   div_q;
  logic [CNW-1:0]  cnt_q;
  logic            run_q;
  logic            done_q;
  logic [DW:0]     rem_sh;
  logic            ge;
  logic [DW:0]     rem_nx;

  assign rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, div_q};
  assign rem_nx = ge ? rem_sh - {1'b0, div_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNW'(NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[design/bet_chk.sv]
// ----------------------------------------------------------------------------
// bet_chk
// Port-level checks for the breakpoint envelope table.
// ----------------------------------------------------------------------------
module bet_chk #(
  parameter int MAX_NODES = bet_pkg::MAX_NODES_DEF
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input bet_pkg::cmd_t    cmd_i,
  input logic             valid_o,
  input bet_pkg::result_t result_o
);

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result shown while busy");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.action == bet_pkg::ACT_CLEAR |=>
      valid_o && result_o.node_total == '0)
    else $error("clear transaction not answered with empty table");

  a_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.action == bet_pkg::ACT_INSERT |=> valid_o && !busy)
    else $error("insert transaction not answered next cycle");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.status == bet_pkg::ST_FULL |->
      result_o.node_total == bet_pkg::TOTAL_W'(MAX_NODES) && result_o.level_out == '0)
    else $error("refused insert with table not full");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> result_o.status == bet_pkg::ST_OK ||
                result_o.status == bet_pkg::ST_FULL ||
                result_o.status == bet_pkg::ST_FEW)
    else $error("bad status code");

endmodule

bind breakpoint_envelope_table bet_chk #(.MAX_NODES(MAX_NODES)) u_bet_chk (.*);
